/* rtl/djs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djs_pkg
// Shared types and constants of the deadline job scheduler.
// ----------------------------------------------------------------------------
package djs_pkg;

	localparam int MaxJobsDef  = 64;
	localparam int MaxSlotsDef = 32;
	localparam int IdW         = 8;
	localparam int DlW         = 6;
	localparam int PrW         = 16;
	localparam int SlotW       = 5;
	localparam int SumW        = 21;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PICK_START,
		ST_PICK_RD,
		ST_PICK_CMP,
		ST_PLACE,
		ST_EMIT_SCAN,
		ST_EMIT_WAIT,
		ST_TOTAL
	} djs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;       // write incoming job into the store
		logic pick_clear;  // start a new maximum search
		logic pick_rd;     // advance the read index
		logic pick_cmp;    // compare the read entry with the best so far
		logic place;       // place the chosen job
		logic emit_step;   // advance the output slot pointer
		logic emit_slot;   // load a slot result into the output register
		logic emit_total;  // load the total result
		logic clear;       // clear batch state
	} djs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_done;     // read index has passed the last stored job
		logic none_left;   // no unplaced job remains
		logic slot_hit;    // current output slot is used
		logic slot_end;    // output slot pointer at last slot
		logic out_busy;    // output register holds a beat not yet taken
	} djs_stat_t;

endpackage
`default_nettype wire

/* rtl/djs_job_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djs_job_if / djs_res_if
// Valid/ready channels for job beats and result beats.
// ----------------------------------------------------------------------------
interface djs_job_if;
	logic                        valid;
	logic                        ready;
	logic [djs_pkg::IdW-1:0]     job_id;
	logic [djs_pkg::DlW-1:0]     deadline;
	logic [djs_pkg::PrW-1:0]     profit;
	logic                        last;
	modport source (output valid, job_id, deadline, profit, last, input ready);
	modport sink   (input valid, job_id, deadline, profit, last, output ready);
endinterface

interface djs_res_if;
	logic                        valid;
	logic                        ready;
	logic [djs_pkg::IdW-1:0]     sched_id;
	logic [djs_pkg::SlotW-1:0]   slot;
	logic [djs_pkg::SumW-1:0]    total_profit;
	logic                        is_total;
	logic                        run_end;
	modport source (output valid, sched_id, slot, total_profit, is_total, run_end,
		input ready);
	modport sink   (input valid, sched_id, slot, total_profit, is_total, run_end,
		output ready);
endinterface
`default_nettype wire

/* rtl/deadline_job_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_job_scheduler
// Greedy job sequencing with deadlines over a batch of stored jobs.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// jin      in   job_id, deadline, profit, last
// rout     out  sched_id, slot, total_profit, is_total, run_end
//
// Jobs load at one beat per cycle. After the last beat, each job is chosen by
// a scan of the job store RAM, and a final scan that finds nothing left ends
// the search before output starts. Output gives one beat per used slot, then
// the total beat; stalls on the result channel stretch it.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_job_scheduler #(
	parameter int MaxJobs  = djs_pkg::MaxJobsDef,
	parameter int MaxSlots = djs_pkg::MaxSlotsDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	djs_job_if.sink   jin,
	djs_res_if.source rout
);
	djs_pkg::djs_cmd_t  cmd;
	djs_pkg::djs_stat_t stat;

	djs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (jin.valid),
		.in_last  (jin.last),
		.in_ready (jin.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	djs_datapath #(.MaxJobs(MaxJobs), .MaxSlots(MaxSlots)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.jin    (jin),
		.rout   (rout)
	);

	a_total_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rout.valid |-> (rout.is_total == rout.run_end))
		else $error("total flag and run end disagree");
	a_total_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rout.valid && rout.is_total) |-> (rout.sched_id == '0 && rout.slot == '0))
		else $error("total beat carries slot data");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_slot || cmd.emit_total) |-> !(rout.valid && !rout.ready))
		else $error("pending result overwritten");
endmodule
`default_nettype wire

/* rtl/djs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djs_ram
// Generic single-port-write, one-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module djs_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/djs_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djs_datapath
// Job store, maximum search, slot table and output register.
// ----------------------------------------------------------------------------
module djs_datapath #(
	parameter int MaxJobs  = djs_pkg::MaxJobsDef,
	parameter int MaxSlots = djs_pkg::MaxSlotsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire djs_pkg::djs_cmd_t  cmd,
	output      djs_pkg::djs_stat_t stat,
	djs_job_if.sink                 jin,
	djs_res_if.source               rout
);
	localparam int JaW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
	localparam int JcW = $clog2(MaxJobs + 1);
	localparam int SaW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
	localparam int EntW = djs_pkg::IdW + djs_pkg::DlW + djs_pkg::PrW;

	logic [JcW-1:0] count_q;
	logic [JcW-1:0] rd_q;      // index of the entry being read
	logic [JcW-1:0] cmp_idx_q; // index whose data appears on rdata
	logic [MaxJobs-1:0] done_q;
	logic           best_vld_q;
	logic [JaW-1:0] best_idx_q;
	logic [EntW-1:0] best_q;
	logic [EntW-1:0] rdata;
	logic [MaxSlots-1:0] used_q;
	logic [djs_pkg::IdW-1:0] owner_q [MaxSlots];
	logic [djs_pkg::SumW-1:0] sum_q;
	logic [SaW-1:0] eptr_q;
	logic           ovld_q;
	logic [djs_pkg::IdW-1:0] oid_q;
	logic [djs_pkg::SlotW-1:0] oslot_q;
	logic [djs_pkg::SumW-1:0] osum_q;
	logic           otot_q;

	logic [djs_pkg::PrW-1:0] rd_pr, best_pr;
	logic [djs_pkg::DlW-1:0] best_dl;
	logic [djs_pkg::IdW-1:0] best_id;
	logic           can_store;
	logic           have_slot;
	logic [SaW-1:0] free_slot;
	logic [djs_pkg::SumW:0] sum_nx;

	assign can_store = (count_q != JcW'(MaxJobs));
	assign rd_pr   = rdata[djs_pkg::PrW-1:0];
	assign best_pr = best_q[djs_pkg::PrW-1:0];
	assign best_dl = best_q[djs_pkg::PrW +: djs_pkg::DlW];
	assign best_id = best_q[djs_pkg::PrW + djs_pkg::DlW +: djs_pkg::IdW];

	djs_ram #(.Width(EntW), .Depth(MaxJobs)) u_store (
		.clk   (clk),
		.we    (cmd.store && can_store),
		.waddr (count_q[JaW-1:0]),
		.wdata ({jin.job_id, jin.deadline, jin.profit}),
		.raddr (rd_q[JaW-1:0]),
		.rdata (rdata)
	);

	// Latest free slot at or before the clamped deadline; a priority search
	// over the used bits, one slot per term.
	always_comb begin
		have_slot = 1'b0;
		free_slot = '0;
		for (int s = 0; s < MaxSlots; s++) begin
			if (!used_q[s] && (32'(best_dl) > 32'(s))) begin
				have_slot = 1'b1;
				free_slot = SaW'(s);
			end
		end
	end

	assign sum_nx = {1'b0, sum_q} + (djs_pkg::SumW+1)'(best_pr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_q       <= '0;
			cmp_idx_q  <= '0;
			done_q     <= '0;
			best_vld_q <= 1'b0;
			used_q     <= '0;
			sum_q      <= '0;
			eptr_q     <= '0;
			ovld_q     <= 1'b0;
		end else begin
			if (cmd.store && can_store) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.pick_clear) begin
				rd_q       <= '0;
				best_vld_q <= 1'b0;
			end
			if (cmd.pick_rd) begin
				cmp_idx_q <= rd_q;
				rd_q      <= rd_q + 1'b1;
			end
			// Strictly greater keeps the earliest of equal profits.
			if (cmd.pick_cmp && !done_q[cmp_idx_q[JaW-1:0]] &&
				(!best_vld_q || rd_pr > best_pr)) begin
				best_vld_q <= 1'b1;
			end
			if (cmd.place) begin
				done_q[best_idx_q] <= 1'b1;
				if (have_slot) begin
					used_q[free_slot] <= 1'b1;
					sum_q <= sum_nx[djs_pkg::SumW] ? djs_pkg::SumMax
						: sum_nx[djs_pkg::SumW-1:0];
				end
			end
			if (cmd.emit_step) begin
				eptr_q <= eptr_q + 1'b1;
			end
			if (rout.valid && rout.ready) begin
				ovld_q <= 1'b0;
			end
			if (cmd.emit_slot || cmd.emit_total) begin
				ovld_q <= 1'b1;
			end
			if (cmd.clear) begin
				count_q <= '0;
				done_q  <= '0;
				used_q  <= '0;
				sum_q   <= '0;
				eptr_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick_cmp && !done_q[cmp_idx_q[JaW-1:0]] &&
			(!best_vld_q || rd_pr > best_pr)) begin
			best_q     <= rdata;
			best_idx_q <= cmp_idx_q[JaW-1:0];
		end
		if (cmd.place && have_slot) begin
			owner_q[free_slot] <= best_id;
		end
		if (cmd.emit_slot) begin
			oid_q   <= owner_q[eptr_q];
			oslot_q <= djs_pkg::SlotW'(eptr_q);
			osum_q  <= '0;
			otot_q  <= 1'b0;
		end else if (cmd.emit_total) begin
			oid_q   <= '0;
			oslot_q <= '0;
			osum_q  <= sum_q;
			otot_q  <= 1'b1;
		end
	end

	assign stat.rd_done   = (rd_q == count_q);
	assign stat.none_left = !best_vld_q;
	assign stat.slot_hit  = used_q[eptr_q];
	assign stat.slot_end  = (eptr_q == SaW'(MaxSlots - 1));
	assign stat.out_busy  = ovld_q && !rout.ready;

	assign rout.valid        = ovld_q;
	assign rout.sched_id     = oid_q;
	assign rout.slot         = oslot_q;
	assign rout.total_profit = osum_q;
	assign rout.is_total     = otot_q;
	assign rout.run_end      = otot_q;
endmodule
`default_nettype wire

/* rtl/djs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// djs_ctrl
// Sequencer: load, repeated maximum search and placement, then emission.
// ----------------------------------------------------------------------------
module djs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	output      logic               in_ready,
	input  wire djs_pkg::djs_stat_t stat,
	output      djs_pkg::djs_cmd_t  cmd
);
	djs_pkg::djs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= djs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			djs_pkg::ST_LOAD: begin
				if (in_valid && in_last) state_d = djs_pkg::ST_PICK_START;
			end
			djs_pkg::ST_PICK_START: state_d = djs_pkg::ST_PICK_RD;
			djs_pkg::ST_PICK_RD: begin
				if (stat.rd_done) state_d = djs_pkg::ST_PLACE;
				else state_d = djs_pkg::ST_PICK_CMP;
			end
			djs_pkg::ST_PICK_CMP: state_d = djs_pkg::ST_PICK_RD;
			djs_pkg::ST_PLACE: begin
				if (stat.none_left) state_d = djs_pkg::ST_EMIT_SCAN;
				else state_d = djs_pkg::ST_PICK_START;
			end
			djs_pkg::ST_EMIT_SCAN: begin
				if (stat.out_busy) state_d = djs_pkg::ST_EMIT_SCAN;
				else if (stat.slot_end) state_d = djs_pkg::ST_TOTAL;
			end
			djs_pkg::ST_EMIT_WAIT: state_d = djs_pkg::ST_EMIT_SCAN;
			djs_pkg::ST_TOTAL: begin
				if (!stat.out_busy) state_d = djs_pkg::ST_LOAD;
			end
			default: state_d = djs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			djs_pkg::ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
			end
			djs_pkg::ST_PICK_START: begin
				cmd.pick_clear = 1'b1;
			end
			djs_pkg::ST_PICK_RD: begin
				cmd.pick_rd = !stat.rd_done;
			end
			djs_pkg::ST_PICK_CMP: begin
				cmd.pick_cmp = 1'b1;
			end
			djs_pkg::ST_PLACE: begin
				cmd.place = !stat.none_left;
			end
			djs_pkg::ST_EMIT_SCAN: begin
				if (!stat.out_busy) begin
					cmd.emit_slot = stat.slot_hit;
					cmd.emit_step = !stat.slot_end;
				end
			end
			djs_pkg::ST_EMIT_WAIT: begin
				cmd = '0;
			end
			djs_pkg::ST_TOTAL: begin
				if (!stat.out_busy) begin
					cmd.emit_total = 1'b1;
					cmd.clear      = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

/* verif/tb_deadline_job_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_job_scheduler
// Self-checking bench for the deadline job scheduler. Batches of jobs are
// sent with random gaps while the result side stalls at random. A scoreboard
// recomputes each greedy schedule: a stable descending-profit ranking, then
// placement in the latest free slot. Every result beat is compared with the
// oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb_deadline_job_scheduler;
	import djs_pkg::*;

	localparam int NumJobs   = MaxJobsDef;
	localparam int NumSlots  = MaxSlotsDef;
	localparam int CycleCap  = 1500000;
	localparam int RandItems = 100;

	typedef struct {
		logic [IdW-1:0]   sched_id;
		logic [SlotW-1:0] slot;
		logic [SumW-1:0]  total_profit;
		logic             is_total;
		logic             run_end;
	} sched_beat_t;

	class sched_scoreboard;
		logic [IdW-1:0] job_ids [NumJobs];
		logic [DlW-1:0] job_dls [NumJobs];
		logic [PrW-1:0] job_prs [NumJobs];
		int             held;
		sched_beat_t    due_q [$];
		int             errors;
		int             batches;
		int             beats_seen;

		function new();
			held = 0;
			errors = 0;
			batches = 0;
			beats_seen = 0;
		endfunction

		// Stores one accepted job and, on the closing job, queues the schedule.
		function void note_job(logic [IdW-1:0] id, logic [DlW-1:0] dl,
				logic [PrW-1:0] pr, logic fin);
			int          rank [NumJobs];
			bit          taken [NumSlots];
			logic [IdW-1:0] owner [NumSlots];
			logic [SumW:0] sum;
			int          i, j, k, s, d;
			sched_beat_t b;
			if (held < NumJobs) begin
				job_ids[held] = id;
				job_dls[held] = dl;
				job_prs[held] = pr;
				held++;
			end
			if (!fin)
				return;
			for (i = 0; i < held; i++) begin
				j = i;
				while (j > 0 && job_prs[rank[j-1]] < job_prs[i]) begin
					rank[j] = rank[j-1];
					j--;
				end
				rank[j] = i;
			end
			foreach (taken[s])
				taken[s] = 1'b0;
			sum = '0;
			for (i = 0; i < held; i++) begin
				k = rank[i];
				d = (job_dls[k] > NumSlots) ? NumSlots : job_dls[k];
				for (s = d - 1; s >= 0; s--) begin
					if (!taken[s]) begin
						taken[s] = 1'b1;
						owner[s] = job_ids[k];
						sum += job_prs[k];
						if (sum > SumMax)
							sum = SumMax;
						break;
					end
				end
			end
			for (s = 0; s < NumSlots; s++) begin
				if (taken[s]) begin
					b.sched_id = owner[s];
					b.slot = s[SlotW-1:0];
					b.total_profit = '0;
					b.is_total = 1'b0;
					b.run_end = 1'b0;
					due_q.push_back(b);
				end
			end
			b.sched_id = '0;
			b.slot = '0;
			b.total_profit = sum[SumW-1:0];
			b.is_total = 1'b1;
			b.run_end = 1'b1;
			due_q.push_back(b);
			held = 0;
			batches++;
		endfunction

		function void check_beat(sched_beat_t got);
			sched_beat_t want;
			beats_seen++;
			if (due_q.size() == 0) begin
				$error("unexpected result beat: id %0d slot %0d total %0d",
					got.sched_id, got.slot, got.total_profit);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (got.sched_id !== want.sched_id) begin
				$error("sched_id: expected %0d, got %0d", want.sched_id, got.sched_id);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				errors++;
			end
			if (got.total_profit !== want.total_profit) begin
				$error("total_profit: expected %0d, got %0d", want.total_profit,
					got.total_profit);
				errors++;
			end
			if (got.is_total !== want.is_total) begin
				$error("is_total: expected %0d, got %0d", want.is_total, got.is_total);
				errors++;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent;
	int   res_hold;
	bit   res_steady;
	bit   job_steady;
	sched_scoreboard sb;

	djs_job_if jin ();
	djs_res_if rout ();

	deadline_job_scheduler dut (
		.clk   (clk),
		.arst_n(arst_n),
		.jin   (jin),
		.rout  (rout)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleCap) begin
			$display("deadline_job_scheduler: mismatch");
			$finish;
		end
	end

	// Result side: a random stall after each beat, none while steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rout.ready <= 1'b0;
			res_hold = 0;
		end else if (rout.valid && rout.ready) begin
			res_hold = res_steady ? 0 : $urandom_range(0, 3);
			rout.ready <= (res_hold == 0);
		end else if (res_hold > 0) begin
			res_hold = res_hold - 1;
			rout.ready <= (res_hold == 0);
		end else begin
			rout.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sched_beat_t got;
		if (arst_n && rout.valid && rout.ready) begin
			got.sched_id = rout.sched_id;
			got.slot = rout.slot;
			got.total_profit = rout.total_profit;
			got.is_total = rout.is_total;
			got.run_end = rout.run_end;
			sb.check_beat(got);
		end
	end

	// Drives one job beat; valid is only lowered when a gap precedes the beat.
	task automatic send_job(logic [IdW-1:0] id, logic [DlW-1:0] dl,
			logic [PrW-1:0] pr, logic fin);
		int gap;
		gap = job_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			jin.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		jin.valid <= 1'b1;
		jin.job_id <= id;
		jin.deadline <= dl;
		jin.profit <= pr;
		jin.last <= fin;
		do @(posedge clk); while (!jin.ready);
		sb.note_job(id, dl, pr, fin);
		sent++;
	endtask

	task automatic send_batch(int count);
		logic [DlW-1:0] dl;
		for (int i = 0; i < count; i++) begin
			dl = ($urandom_range(0, 4) == 0) ? DlW'($urandom_range(0, 63))
				: DlW'($urandom_range(0, 32));
			send_job(IdW'($urandom), dl, PrW'($urandom), i == count - 1);
		end
	endtask

	initial begin
		int n;
		sb = new();
		cycles = 0;
		sent = 0;
		res_steady = 1'b0;
		job_steady = 1'b0;
		arst_n = 1'b0;
		jin.valid = 1'b0;
		jin.job_id = '0;
		jin.deadline = '0;
		jin.profit = '0;
		jin.last = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the dash id, zero deadline, deadline past the slots,
		// extreme profits and a tie that must keep arrival order.
		send_job(8'h2D, 6'd1, 16'd100, 1'b0);
		send_job(8'h00, 6'd0, 16'hFFFF, 1'b0);
		send_job(8'hFF, 6'd63, 16'hFFFF, 1'b0);
		send_job(8'h07, 6'd2, 16'd100, 1'b0);
		send_job(8'h08, 6'd1, 16'd0, 1'b1);
		send_job(8'h09, 6'd32, 16'd0, 1'b1);
		send_job(8'h0A, 6'd33, 16'd5, 1'b1);
		send_job(8'h0B, 6'd0, 16'd9, 1'b1);
		// Several jobs competing for slot zero; only the first of equals wins.
		send_job(8'h10, 6'd1, 16'd50, 1'b0);
		send_job(8'h11, 6'd1, 16'd50, 1'b0);
		send_job(8'h12, 6'd1, 16'd50, 1'b0);
		send_job(8'h13, 6'd2, 16'd49, 1'b1);
		// Deadlines past the end take the top slots in profit order.
		for (int i = 0; i < 4; i++)
			send_job(IdW'(8'h20 + i), 6'd40, PrW'(16'hFFFF - i), i == 3);

		// Hold the sender until the scoreboard has drained once.
		jin.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		// A full store, with jobs past capacity including the closing one.
		send_batch(NumJobs + 3);
		while (sent < RandItems + 16) begin
			job_steady = ($urandom_range(0, 5) == 0);
			res_steady = ($urandom_range(0, 5) == 0);
			n = $urandom_range(1, 8);
			send_batch(n);
		end
		job_steady = 1'b0;
		res_steady = 1'b1;
		send_batch(NumJobs);

		jin.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d jobs in %0d batches; %0d result beats checked.",
			sent, sb.batches, sb.beats_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("deadline_job_scheduler: match");
		else
			$display("deadline_job_scheduler: mismatch");
		$finish;
	end

endmodule

/* files.f */
rtl/djs_pkg.sv
rtl/djs_job_if.sv
rtl/djs_ram.sv
rtl/djs_datapath.sv
rtl/djs_ctrl.sv
rtl/deadline_job_scheduler.sv
verif/tb_deadline_job_scheduler.sv
